// ----- rtl/core/bsst_pkg.sv -----
// Package for the bounded sorted score table: field widths, codes, FSM state type.
// Used by bounded_sorted_score_table_core; depends on nothing.
`default_nettype none

package bsst_pkg;

  localparam int unsigned CapacityDef = 128;
  localparam int unsigned PointsW     = 32;
  localparam int unsigned TagW        = 64;
  localparam int unsigned RankW       = 7;
  localparam int unsigned OutW        = 8;
  localparam int unsigned EntryW      = PointsW + TagW;

  localparam logic KindInsert = 1'b0;
  localparam logic KindRead   = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_PLACE,
    S_FETCH
  } state_e;

endpackage

`default_nettype wire

// ----- rtl/core/bounded_sorted_score_table_core.sv -----
// Bounded sorted score table: top level holding the entry memory and its sequencer.
// Depends on bsst_pkg.
`default_nettype none

// Keeps up to CAPACITY entries (signed points and a 64-bit name tag) sorted
// by descending points in one single-port-write, one-port-read memory with a
// registered read. Raise start_i with the word on kind_i, points_i,
// name_tag_i and rank_i; the word is taken at a clock edge where busy_o is
// low. Exactly one result word follows on the result ports, marked by done_o
// high for one cycle; the receiver cannot stall, so capture it then.
// A read fetches the entry at rank_i through the registered read; a rank not
// below the count is answered without a fetch. An insert walks the table from
// the bottom, one memory entry per cycle, moving every entry with strictly
// lower points one rank down as it goes; the memory read port sets its pace.
// A new word may be accepted in the cycle its predecessor's result is shown.
// Equal points keep the older entry ahead; on a full table the lowest entry
// falls off, which may be the new one (placed_at = CAPACITY, truncated to 8
// bits, was_dropped = 1). The memory is not cleared: only ranks below the
// count are ever returned.
module bounded_sorted_score_table_core #(
  parameter int unsigned CAPACITY = bsst_pkg::CapacityDef
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 start_i,
  output logic                                busy_o,
  input  wire                                 kind_i,
  input  wire  signed [bsst_pkg::PointsW-1:0] points_i,
  input  wire         [bsst_pkg::TagW-1:0]    name_tag_i,
  input  wire         [bsst_pkg::RankW-1:0]   rank_i,
  output logic                                done_o,
  output logic        [bsst_pkg::OutW-1:0]    placed_at_o,
  output logic                                was_dropped_o,
  output logic                                entry_valid_o,
  output logic signed [bsst_pkg::PointsW-1:0] entry_points_o,
  output logic        [bsst_pkg::TagW-1:0]    entry_tag_o,
  output logic        [bsst_pkg::OutW-1:0]    entry_count_o
);

  localparam int unsigned AW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW  = $clog2(CAPACITY + 1);
  localparam int unsigned PW  = (CW > bsst_pkg::OutW) ? CW : bsst_pkg::OutW;
  localparam int unsigned RW  = (CW > bsst_pkg::RankW) ? CW : bsst_pkg::RankW;
  localparam int unsigned EW  = bsst_pkg::EntryW;
  localparam logic [CW-1:0] CapC = CW'(CAPACITY);

  // Entry memory: points in the upper bits, tag in the lower bits.
  logic [EW-1:0] mem_q [CAPACITY];
  logic [EW-1:0] rdata_q;
  logic [AW-1:0] raddr;
  logic          we;
  logic [AW-1:0] waddr;
  logic [EW-1:0] wdata;

  bsst_pkg::state_e state_q, state_d;
  logic [AW-1:0] idx_q, idx_d;
  logic [CW-1:0] pos_q, pos_d;
  logic [CW-1:0] count_q, count_d;

  logic signed [bsst_pkg::PointsW-1:0] points_q;
  logic        [bsst_pkg::TagW-1:0]    tag_q;

  // Result word, held for one strobe cycle.
  logic                                done_q;
  logic        [bsst_pkg::OutW-1:0]    placed_q;
  logic                                dropped_q;
  logic                                evalid_q;
  logic signed [bsst_pkg::PointsW-1:0] epts_q;
  logic        [bsst_pkg::TagW-1:0]    etag_q;

  logic                                emit;
  logic        [bsst_pkg::OutW-1:0]    emit_placed;
  logic                                emit_dropped;
  logic                                emit_valid;

  logic                                accept;
  logic        [RW-1:0]                rank_ext;
  logic        [RW-1:0]                count_ext;
  logic                                rank_ok;
  logic signed [bsst_pkg::PointsW-1:0] rd_pts;
  logic                                rd_lower;
  logic        [CW-1:0]                below;
  logic        [PW-1:0]                pos_wide;
  logic        [PW-1:0]                cap_wide;
  logic        [PW-1:0]                cnt_wide;

  assign accept    = start_i && (state_q == bsst_pkg::S_IDLE);
  assign busy_o    = (state_q != bsst_pkg::S_IDLE);
  assign rank_ext  = RW'(rank_i);
  assign count_ext = RW'(count_q);
  assign rank_ok   = (rank_ext < count_ext);
  assign rd_pts    = rdata_q[EW-1 -: bsst_pkg::PointsW];
  assign rd_lower  = (rd_pts < points_q);
  assign below     = CW'(idx_q) + CW'(1);
  assign pos_wide  = PW'(pos_q);
  assign cap_wide  = PW'(CapC);
  assign cnt_wide  = PW'(count_q);

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    pos_d        = pos_q;
    count_d      = count_q;
    raddr        = idx_q;
    we           = 1'b0;
    waddr        = AW'(below);
    wdata        = rdata_q;
    emit         = 1'b0;
    emit_placed  = '0;
    emit_dropped = 1'b0;
    emit_valid   = 1'b0;
    unique case (state_q)
      bsst_pkg::S_IDLE: begin
        // Start the bottom entry's read for an insert, the rank's for a read.
        if (kind_i == bsst_pkg::KindInsert) begin
          raddr = AW'(count_q - CW'(1));
        end else begin
          raddr = AW'(rank_i);
        end
        if (accept) begin
          if (kind_i == bsst_pkg::KindInsert) begin
            if (count_q == '0) begin
              pos_d   = '0;
              state_d = bsst_pkg::S_PLACE;
            end else begin
              idx_d   = AW'(count_q - CW'(1));
              state_d = bsst_pkg::S_SCAN;
            end
          end else if (rank_ok) begin
            state_d = bsst_pkg::S_FETCH;
          end else begin
            emit = 1'b1;
          end
        end
      end
      bsst_pkg::S_SCAN: begin
        if (rd_lower) begin
          // Move the lower entry down a rank; the bottom one of a full table drops.
          we = (below != CapC);
          if (idx_q == '0) begin
            pos_d   = '0;
            state_d = bsst_pkg::S_PLACE;
          end else begin
            raddr   = idx_q - AW'(1);
            idx_d   = idx_q - AW'(1);
          end
        end else begin
          pos_d = below;
          if (below == CapC) begin
            // Table full and the new entry is not above the lowest: drop it.
            emit         = 1'b1;
            emit_placed  = cap_wide[bsst_pkg::OutW-1:0];
            emit_dropped = 1'b1;
            state_d      = bsst_pkg::S_IDLE;
          end else begin
            state_d = bsst_pkg::S_PLACE;
          end
        end
      end
      bsst_pkg::S_PLACE: begin
        we          = 1'b1;
        waddr       = AW'(pos_q);
        wdata       = {points_q, tag_q};
        emit        = 1'b1;
        emit_placed = pos_wide[bsst_pkg::OutW-1:0];
        if (count_q != CapC) begin
          count_d = count_q + CW'(1);
        end
        state_d = bsst_pkg::S_IDLE;
      end
      bsst_pkg::S_FETCH: begin
        emit       = 1'b1;
        emit_valid = 1'b1;
        state_d    = bsst_pkg::S_IDLE;
      end
      default: begin
        state_d = bsst_pkg::S_IDLE;
      end
    endcase
  end

  // Memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bsst_pkg::S_IDLE;
      idx_q   <= '0;
      pos_q   <= '0;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      pos_q   <= pos_d;
      count_q <= count_d;
      done_q  <= emit;
    end
  end

  // Hold the new entry for the whole walk.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      points_q <= points_i;
      tag_q    <= name_tag_i;
    end
  end

  // Load the result word; data fields read as zero unless a valid read.
  always_ff @(posedge clk_i) begin
    if (emit) begin
      placed_q  <= emit_placed;
      dropped_q <= emit_dropped;
      evalid_q  <= emit_valid;
      if (emit_valid) begin
        epts_q <= rd_pts;
        etag_q <= rdata_q[bsst_pkg::TagW-1:0];
      end else begin
        epts_q <= '0;
        etag_q <= '0;
      end
    end
  end

  assign done_o         = done_q;
  assign placed_at_o    = placed_q;
  assign was_dropped_o  = dropped_q;
  assign entry_valid_o  = evalid_q;
  assign entry_points_o = epts_q;
  assign entry_tag_o    = etag_q;
  assign entry_count_o  = cnt_wide[bsst_pkg::OutW-1:0];

endmodule

`default_nettype wire
